// ===== rtl/core/wmdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint decimator package
// Shared types and fixed constants of the waypoint decimator.
// ----------------------------------------------------------------------------
package wmdd_pkg;

    // Width of the minimum spacing register, in Q.8 metres.
    localparam int SPACING_W = 24;

    // Result slots that one waypoint can release, in delivery order.
    localparam int NUM_RES = 3;
    localparam int RES_OLD = 0;   // previously held point, now superseded
    localparam int RES_MID = 1;   // inserted midpoint of a two-point path
    localparam int RES_END = 2;   // held point closing the path

    // Classification the front end attaches to every waypoint.
    typedef struct packed {
        logic first;   // first waypoint of a path
        logic fin;     // last waypoint of a path
    } t_item_flags;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQX,
        F_SQY,
        F_ROOT,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SUM,
        B_DECIDE,
        B_EMIT
    } t_back_state;

endpackage

// ===== rtl/core/wmdd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint decimator queue
// Small first-in first-out queue of registers with full and empty flags.
// ----------------------------------------------------------------------------
module wmdd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds its depth");
`endif

endmodule

// ===== rtl/core/wmdd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint decimator front end
// Accepts waypoints, marks path starts and computes the step distance.
// ----------------------------------------------------------------------------
module wmdd_front #(
    parameter int CW = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [CW-1:0]         i_pos_x,
    input  logic [CW-1:0]         i_pos_y,
    input  logic                  i_final_point,
    output logic                  o_q_push,
    input  logic                  i_q_full,
    output logic [CW-1:0]         o_q_x,
    output logic [CW-1:0]         o_q_y,
    output logic [CW:0]           o_q_dist,
    output wmdd_pkg::t_item_flags o_q_flags
);

    localparam int RW = 2 * CW + 2;
    localparam int CNT_W = $clog2(CW + 1);

    wmdd_pkg::t_front_state r_state;
    wmdd_pkg::t_front_state n_state;
    logic                   r_in_path;

    logic [CW-1:0]         r_x;
    logic [CW-1:0]         r_y;
    logic [CW-1:0]         r_prev_x;
    logic [CW-1:0]         r_prev_y;
    logic [CW-1:0]         r_dx;
    logic [CW-1:0]         r_dy;
    logic [RW-1:0]         r_rad;
    logic [CW+1:0]         r_rem;
    logic [CW:0]           r_root;
    logic [CNT_W-1:0]      r_cnt;
    wmdd_pkg::t_item_flags r_flags;

    logic            accept;
    logic [CW:0]     diff_x;
    logic [CW:0]     diff_y;
    logic [CW:0]     neg_x;
    logic [CW:0]     neg_y;
    logic [CW-1:0]   abs_x;
    logic [CW-1:0]   abs_y;
    logic [CW-1:0]   mul_a;
    logic [2*CW-1:0] prod;
    logic [CW+3:0]   rem_sh;
    logic [CW+3:0]   trial;
    logic [CW+3:0]   rem_diff;
    logic            root_bit;
    logic [CW+1:0]   step_rem;
    logic [CW:0]     step_root;

    assign accept = i_push && !o_full;

    // Absolute coordinate differences to the previous waypoint.
    always_comb begin
        diff_x = {i_pos_x[CW-1], i_pos_x} - {r_prev_x[CW-1], r_prev_x};
        diff_y = {i_pos_y[CW-1], i_pos_y} - {r_prev_y[CW-1], r_prev_y};
        neg_x  = -diff_x;
        neg_y  = -diff_y;
        abs_x  = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
        abs_y  = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];
    end

    // One multiplier squares dx, then dy.
    assign mul_a = (r_state == wmdd_pkg::F_SQX) ? r_dx : r_dy;
    assign prod  = mul_a * mul_a;

    // One root bit per cycle, restoring digit-by-digit square root.
    always_comb begin
        rem_sh    = {r_rem, r_rad[RW-1:RW-2]};
        trial     = {1'b0, r_root, 2'b01};
        rem_diff  = rem_sh - trial;
        root_bit  = (rem_sh >= trial);
        step_rem  = root_bit ? rem_diff[CW+1:0] : rem_sh[CW+1:0];
        step_root = {r_root[CW-1:0], root_bit};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wmdd_pkg::F_IDLE: begin
                if (i_push) begin
                    n_state = r_in_path ? wmdd_pkg::F_SQX : wmdd_pkg::F_PUSH;
                end
            end
            wmdd_pkg::F_SQX:  n_state = wmdd_pkg::F_SQY;
            wmdd_pkg::F_SQY:  n_state = wmdd_pkg::F_ROOT;
            wmdd_pkg::F_ROOT: begin
                if (r_cnt == '0) begin
                    n_state = wmdd_pkg::F_PUSH;
                end
            end
            wmdd_pkg::F_PUSH: begin
                if (!i_q_full) begin
                    n_state = wmdd_pkg::F_IDLE;
                end
            end
            default: n_state = wmdd_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_full   = (r_state != wmdd_pkg::F_IDLE);
        o_q_push = (r_state == wmdd_pkg::F_PUSH);
    end

    assign o_q_x     = r_x;
    assign o_q_y     = r_y;
    assign o_q_dist  = r_root;
    assign o_q_flags = r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wmdd_pkg::F_IDLE;
            r_in_path <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_in_path <= !i_final_point;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wmdd_pkg::F_IDLE: begin
                if (accept) begin
                    r_x           <= i_pos_x;
                    r_y           <= i_pos_y;
                    r_prev_x      <= i_pos_x;
                    r_prev_y      <= i_pos_y;
                    r_dx          <= abs_x;
                    r_dy          <= abs_y;
                    r_root        <= '0;
                    r_flags.first <= !r_in_path;
                    r_flags.fin   <= i_final_point;
                end
            end
            wmdd_pkg::F_SQX: begin
                r_rad <= {2'b00, prod};
            end
            wmdd_pkg::F_SQY: begin
                r_rad  <= r_rad + {2'b00, prod};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(CW);
            end
            wmdd_pkg::F_ROOT: begin
                r_rad  <= {r_rad[RW-3:0], 2'b00};
                r_rem  <= step_rem;
                r_root <= step_root;
                r_cnt  <= r_cnt - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wmdd_pkg::F_ROOT) |-> (r_cnt <= CNT_W'(CW)))
        else $error("square root step counter out of range");
`endif

endmodule

// ===== rtl/core/wmdd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint decimator back end
// Sums arc lengths, decides which waypoints are kept and releases results.
// ----------------------------------------------------------------------------
module wmdd_back #(
    parameter int CW = 24,
    parameter int LW = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [wmdd_pkg::SPACING_W-1:0] i_min_spacing,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  logic [CW-1:0]                 i_q_x,
    input  logic [CW-1:0]                 i_q_y,
    input  logic [CW:0]                   i_q_dist,
    input  wmdd_pkg::t_item_flags         i_q_flags,
    output logic                          o_res_push,
    input  logic                          i_res_full,
    output logic [CW-1:0]                 o_res_x,
    output logic [CW-1:0]                 o_res_y,
    output logic [LW-1:0]                 o_res_len,
    output logic                          o_res_eop
);

    localparam int SW = ((LW > CW + 1) ? LW : CW + 1) + 1;
    localparam int MW = (LW > wmdd_pkg::SPACING_W) ? LW : wmdd_pkg::SPACING_W;
    localparam int NR = wmdd_pkg::NUM_RES;

    wmdd_pkg::t_back_state r_state;
    wmdd_pkg::t_back_state n_state;
    logic [NR-1:0]         r_pend;
    logic [NR-1:0]         n_pend;
    logic [1:0]            r_kept;

    logic [CW-1:0]         r_x;
    logic [CW-1:0]         r_y;
    logic [CW:0]           r_dist;
    wmdd_pkg::t_item_flags r_flags;
    logic [LW-1:0]         r_since;
    logic [LW-1:0]         r_total;
    logic [CW-1:0]         r_held_x;
    logic [CW-1:0]         r_held_y;
    logic [LW-1:0]         r_held_len;
    logic [CW-1:0]         r_first_x;
    logic [CW-1:0]         r_first_y;
    logic [CW-1:0]         r_old_x;
    logic [CW-1:0]         r_old_y;
    logic [LW-1:0]         r_old_len;

    logic [SW-1:0] since_sum;
    logic [SW-1:0] total_sum;
    logic [LW-1:0] since_sat;
    logic [LW-1:0] total_sat;
    logic          keep;
    logic [1:0]    kept_inc;
    logic [CW:0]   mid_x_sum;
    logic [CW:0]   mid_y_sum;
    logic [NR-1:0] emit_sel;
    logic          emit_done;
    logic          do_pop;

    assign do_pop = (r_state == wmdd_pkg::B_IDLE) && !i_q_empty;

    // Saturating length sums.
    always_comb begin
        since_sum = SW'(r_since) + SW'(r_dist);
        total_sum = SW'(r_total) + SW'(r_dist);
        since_sat = (since_sum[SW-1:LW] != '0) ? '1 : since_sum[LW-1:0];
        total_sat = (total_sum[SW-1:LW] != '0) ? '1 : total_sum[LW-1:0];
    end

    assign keep     = MW'(r_since) > MW'(i_min_spacing);
    assign kept_inc = (r_kept == 2'd3) ? r_kept : r_kept + 2'd1;

    // Results released by the waypoint under decision.
    always_comb begin
        n_pend = '0;
        if (r_flags.first) begin
            n_pend[wmdd_pkg::RES_END] = r_flags.fin;
        end else begin
            n_pend[wmdd_pkg::RES_OLD] = keep;
            n_pend[wmdd_pkg::RES_MID] = r_flags.fin && ((keep ? kept_inc : r_kept) == 2'd2);
            n_pend[wmdd_pkg::RES_END] = r_flags.fin;
        end
    end

    // The oldest pending result goes first.
    always_comb begin
        emit_sel = '0;
        if (r_pend[wmdd_pkg::RES_OLD]) begin
            emit_sel[wmdd_pkg::RES_OLD] = 1'b1;
        end else if (r_pend[wmdd_pkg::RES_MID]) begin
            emit_sel[wmdd_pkg::RES_MID] = 1'b1;
        end else begin
            emit_sel[wmdd_pkg::RES_END] = r_pend[wmdd_pkg::RES_END];
        end
        emit_done = !i_res_full && ((r_pend & ~emit_sel) == '0);
    end

    // Midpoint of the first and the held point, rounded toward minus infinity.
    always_comb begin
        mid_x_sum = {r_first_x[CW-1], r_first_x} + {r_held_x[CW-1], r_held_x};
        mid_y_sum = {r_first_y[CW-1], r_first_y} + {r_held_y[CW-1], r_held_y};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wmdd_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = wmdd_pkg::B_SUM;
                end
            end
            wmdd_pkg::B_SUM:    n_state = wmdd_pkg::B_DECIDE;
            wmdd_pkg::B_DECIDE: begin
                n_state = (n_pend != '0) ? wmdd_pkg::B_EMIT : wmdd_pkg::B_IDLE;
            end
            wmdd_pkg::B_EMIT: begin
                if (emit_done) begin
                    n_state = wmdd_pkg::B_IDLE;
                end
            end
            default: n_state = wmdd_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop    = do_pop;
        o_res_push = (r_state == wmdd_pkg::B_EMIT);
        if (emit_sel[wmdd_pkg::RES_OLD]) begin
            o_res_x   = r_old_x;
            o_res_y   = r_old_y;
            o_res_len = r_old_len;
            o_res_eop = 1'b0;
        end else if (emit_sel[wmdd_pkg::RES_MID]) begin
            o_res_x   = mid_x_sum[CW:1];
            o_res_y   = mid_y_sum[CW:1];
            o_res_len = {1'b0, r_held_len[LW-1:1]};
            o_res_eop = 1'b0;
        end else begin
            o_res_x   = r_held_x;
            o_res_y   = r_held_y;
            o_res_len = r_held_len;
            o_res_eop = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmdd_pkg::B_IDLE;
            r_pend  <= '0;
            r_kept  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == wmdd_pkg::B_DECIDE) begin
                r_pend <= n_pend;
                if (r_flags.fin) begin
                    r_kept <= '0;
                end else if (r_flags.first) begin
                    r_kept <= 2'd1;
                end else if (keep) begin
                    r_kept <= kept_inc;
                end
            end else if ((r_state == wmdd_pkg::B_EMIT) && !i_res_full) begin
                r_pend <= r_pend & ~emit_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_x     <= i_q_x;
            r_y     <= i_q_y;
            r_dist  <= i_q_dist;
            r_flags <= i_q_flags;
        end
        if ((r_state == wmdd_pkg::B_SUM) && !r_flags.first) begin
            r_since <= since_sat;
            r_total <= total_sat;
        end
        if (r_state == wmdd_pkg::B_DECIDE) begin
            if (r_flags.first) begin
                r_first_x  <= r_x;
                r_first_y  <= r_y;
                r_held_x   <= r_x;
                r_held_y   <= r_y;
                r_held_len <= '0;
                r_since    <= '0;
                r_total    <= '0;
            end else if (keep) begin
                r_old_x    <= r_held_x;
                r_old_y    <= r_held_y;
                r_old_len  <= r_held_len;
                r_held_x   <= r_x;
                r_held_y   <= r_y;
                r_held_len <= r_total;
                r_since    <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_idle_nothing_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wmdd_pkg::B_IDLE) |-> (r_pend == '0))
        else $error("results pending while the back end is idle");

    a_mid_before_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend[wmdd_pkg::RES_MID] |-> r_pend[wmdd_pkg::RES_END])
        else $error("midpoint pending without a closing point");
`endif

endmodule

// ===== rtl/core/waypoint_min_distance_decimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint decimator by arc length
// Thins a waypoint stream so kept points lie more than a minimum path length
// apart, and reports the cumulative arc length of every point sent.
// ----------------------------------------------------------------------------
// Usage:
// Waypoints enter through a queue-style port: a request is taken on a rising
// edge with push high and full low. Results leave the same way: the oldest
// result sits on the o_out_* ports while empty is low and is taken on an edge
// with pop high. The minimum spacing register is written over its own
// valid/ready channel, which is always ready; write it only while idle.
// After a path's first request full stays high until the request has been
// written to the middle queue. After every later request full also stays
// high while the square-root unit, which produces one distance bit per
// cycle, computes the step distance, so a new request is not taken before
// the distance of the last one is done. The back end sums, decides and
// releases results for a waypoint while the front end works on the next.
// A kept point leaves only when the next point is kept or the path ends, so
// results lag by one kept point. Reset clears the queues, the path state and
// the spacing register; no clearing pass is needed. When the receiver stops
// popping, the output queue fills, the back end waits, the middle queue
// fills and full rises; no request is ever lost.
// ----------------------------------------------------------------------------
module waypoint_min_distance_decimator_top #(
    parameter int COORD_WIDTH  = 24,
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wmdd_pkg::SPACING_W-1:0]  i_min_spacing,
    // Waypoint requests.
    input  logic                            push,
    output logic                            full,
    input  logic signed [COORD_WIDTH-1:0]   i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]   i_pos_y,
    input  logic                            i_final_point,
    // Results.
    output logic                            empty,
    input  logic                            pop,
    output logic signed [COORD_WIDTH-1:0]   o_out_x,
    output logic signed [COORD_WIDTH-1:0]   o_out_y,
    output logic [LENGTH_WIDTH-1:0]         o_arc_length,
    output logic                            o_end_of_path
);

    localparam int CW = COORD_WIDTH;
    localparam int LW = LENGTH_WIDTH;
    // Middle queue record: x, y, step distance and the two flags.
    localparam int MID_W = 2 * CW + (CW + 1) + $bits(wmdd_pkg::t_item_flags);
    localparam int MID_DEPTH = 2;
    // Result record: x, y, arc length and end-of-path.
    localparam int RES_W = 2 * CW + LW + 1;
    localparam int RES_DEPTH = 4;

    logic [wmdd_pkg::SPACING_W-1:0] r_min_spacing;

    // Front end to middle queue.
    logic                  f_push;
    logic                  mid_full;
    logic [CW-1:0]         f_x;
    logic [CW-1:0]         f_y;
    logic [CW:0]           f_dist;
    wmdd_pkg::t_item_flags f_flags;
    logic [MID_W-1:0]      mid_wr_data;

    // Middle queue to back end.
    logic                  mid_empty;
    logic                  b_pop;
    logic [MID_W-1:0]      mid_rd_data;
    logic [CW-1:0]         b_x;
    logic [CW-1:0]         b_y;
    logic [CW:0]           b_dist;
    wmdd_pkg::t_item_flags b_flags;

    // Back end to result queue.
    logic                  res_push;
    logic                  res_full;
    logic [CW-1:0]         res_x;
    logic [CW-1:0]         res_y;
    logic [LW-1:0]         res_len;
    logic                  res_eop;
    logic [RES_W-1:0]      res_wr_data;
    logic [RES_W-1:0]      res_rd_data;

    // The spacing register accepts a write in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_spacing <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_spacing <= i_min_spacing;
        end
    end

    // Front end: takes requests, tracks the path start and computes the
    // integer distance to the previous waypoint.
    wmdd_front #(
        .CW (CW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_final_point (i_final_point),
        .o_q_push      (f_push),
        .i_q_full      (mid_full),
        .o_q_x         (f_x),
        .o_q_y         (f_y),
        .o_q_dist      (f_dist),
        .o_q_flags     (f_flags)
    );

    assign mid_wr_data = {f_x, f_y, f_dist, f_flags};

    // Short queue so the distance unit can start on the next waypoint while
    // the back end is still releasing results.
    wmdd_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (mid_wr_data),
        .o_full  (mid_full),
        .i_pop   (b_pop),
        .o_data  (mid_rd_data),
        .o_empty (mid_empty)
    );

    assign {b_x, b_y, b_dist, b_flags} = mid_rd_data;

    // Back end: length sums, keep decision, midpoint insertion.
    wmdd_back #(
        .CW (CW),
        .LW (LW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_min_spacing (r_min_spacing),
        .i_q_empty     (mid_empty),
        .o_q_pop       (b_pop),
        .i_q_x         (b_x),
        .i_q_y         (b_y),
        .i_q_dist      (b_dist),
        .i_q_flags     (b_flags),
        .o_res_push    (res_push),
        .i_res_full    (res_full),
        .o_res_x       (res_x),
        .o_res_y       (res_y),
        .o_res_len     (res_len),
        .o_res_eop     (res_eop)
    );

    assign res_wr_data = {res_x, res_y, res_len, res_eop};

    // Result queue; its head drives the output ports.
    wmdd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wr_data),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rd_data),
        .o_empty (empty)
    );

    assign {o_out_x, o_out_y, o_arc_length, o_end_of_path} = res_rd_data;

`ifndef SYNTHESIS
    a_res_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && res_full) |=> (res_push && $stable(res_wr_data)))
        else $error("result dropped while the result queue was full");
`endif

endmodule
